// ----- design/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types, constants and helpers for the motor speed ramp.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int SPEED_W   = 10;
    localparam int SHIFT_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 2;

    // Command ceiling; the effective limit is the lower of this and full scale.
    localparam int SPEED_MAX = 1023;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT =
        (SPEED_MAX < 1023) ? SPEED_W'(SPEED_MAX) : SPEED_W'(1023);

    localparam logic [SPEED_W-1:0] SNAP_BAND  = SPEED_W'(25);
    localparam logic [SPEED_W-1:0] BRAKE_MIN  = SPEED_W'(50);
    localparam logic [SPEED_W-1:0] DUTY_TOP   = SPEED_W'(1023);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SHIFT = 1'b0,
        CFG_INVERT_REV = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               direction;
    } msr_state_t;

    // Floor divide by five for a 10-bit value: reciprocal multiply, exact below 1024.
    function automatic logic [SPEED_W-1:0] div5(input logic [SPEED_W-1:0] x);
        logic [17:0] prod;
        prod = {8'd0, x} * 18'd205;
        return {2'b00, prod[17:10]};
    endfunction

endpackage

// ----- design/msr_ramp.sv -----
// ----------------------------------------------------------------------------
// msr_ramp
// One ramp step: direction takeover, braking and approach toward the command.
// ----------------------------------------------------------------------------
module msr_ramp (
    input  msr_pkg::msr_state_t                  state,
    input  logic [msr_pkg::SPEED_W-1:0]          target_speed,
    input  logic                                 target_direction,
    input  logic                                 motor_fault,
    output msr_pkg::msr_state_t                  state_next
);
    import msr_pkg::*;

    logic [SPEED_W-1:0] target;
    logic               dir_applied;
    logic [SPEED_W-1:0] brake1;
    logic [SPEED_W-1:0] brake2;
    logic [SPEED_W-1:0] diff_up;
    logic [SPEED_W-1:0] diff_down;
    logic [SPEED_W-1:0] speed_new;

    always_comb
    begin
        target = (target_speed > SPEED_LIMIT) ? SPEED_LIMIT : target_speed;
        if (motor_fault)
        begin
            target = '0;
        end

        // Take the commanded direction only when starting from standstill
        dir_applied = (state.speed == '0 && target != '0) ? target_direction
                                                         : state.direction;

        brake1    = state.speed - div5(state.speed);
        brake2    = brake1 - div5(brake1);
        diff_up   = target - state.speed;
        diff_down = state.speed - target;

        if (dir_applied != target_direction)
        begin
            if (state.speed == '0)
            begin
                speed_new = '0;
            end
            else if (brake1 > BRAKE_MIN)
            begin
                speed_new = brake2;
            end
            else
            begin
                speed_new = '0;
            end
        end
        else if (target > state.speed)
        begin
            speed_new = (diff_up > SNAP_BAND) ? state.speed + div5(diff_up) : target;
        end
        else if (target < state.speed)
        begin
            speed_new = (diff_down > SNAP_BAND) ? state.speed - div5(diff_down) : target;
        end
        else
        begin
            speed_new = state.speed;
        end

        state_next.speed     = speed_new;
        state_next.direction = dir_applied;
    end

endmodule

// ----- design/msr_duty.sv -----
// ----------------------------------------------------------------------------
// msr_duty
// PWM compare value from the ramped speed, with optional reverse inversion.
// ----------------------------------------------------------------------------
module msr_duty (
    input  msr_pkg::msr_state_t                  state,
    input  logic [msr_pkg::SHIFT_W-1:0]          step_shift,
    input  logic                                 invert_in_reverse,
    output logic [msr_pkg::SPEED_W-1:0]          pwm_duty
);
    import msr_pkg::*;

    logic [SPEED_W-1:0] shifted;
    logic [SPEED_W-1:0] top;

    always_comb
    begin
        shifted = state.speed >> step_shift;
        top     = DUTY_TOP >> step_shift;
        if (invert_in_reverse && state.direction)
        begin
            pwm_duty = top - shifted;
        end
        else
        begin
            pwm_duty = shifted;
        end
    end

endmodule

// ----- design/motor_speed_ramp_top.sv -----
// Ticks pass the input register, then the result register. Throughput: one tick
// per cycle unless out_ready holds the result; the held speed and direction
// registers close the loop combinationally; back-to-back ticks need no stall.
// Reset (rst_n low, asynchronous): speed zero, direction forward, step_shift 0,
// invert_in_reverse 0, both stages empty.
// ----------------------------------------------------------------------------
// motor_speed_ramp_top
// Input register, ramp step and duty mapping, result register.
// ----------------------------------------------------------------------------
module motor_speed_ramp_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [msr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msr_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [msr_pkg::SPEED_W-1:0]          target_speed,
    input  logic                                 target_direction,
    input  logic                                 motor_fault,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msr_pkg::SPEED_W-1:0]          pwm_duty,
    output logic                                 drive_direction,
    output logic [msr_pkg::SPEED_W-1:0]          current_speed
);
    import msr_pkg::*;

    logic [SHIFT_W-1:0] step_shift_reg;
    logic               invert_reg;

    logic               in_valid_reg;
    logic [SPEED_W-1:0] target_speed_reg;
    logic               target_dir_reg;
    logic               fault_reg;

    msr_state_t         state_reg;
    msr_state_t         state_next;
    logic [SPEED_W-1:0] duty_next;

    logic               out_valid_reg;
    logic [SPEED_W-1:0] duty_reg;

    logic               advance;
    logic               fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_shift_reg <= '0;
            invert_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_SHIFT: step_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_INVERT_REV: invert_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Input stage: hold the transaction while the result stage is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            target_speed_reg <= target_speed;
            target_dir_reg   <= target_direction;
            fault_reg        <= motor_fault;
        end
    end

    msr_ramp u_ramp (
        .state            (state_reg),
        .target_speed     (target_speed_reg),
        .target_direction (target_dir_reg),
        .motor_fault      (fault_reg),
        .state_next       (state_next)
    );

    msr_duty u_duty (
        .state             (state_next),
        .step_shift        (step_shift_reg),
        .invert_in_reverse (invert_reg),
        .pwm_duty          (duty_next)
    );

    // Held state doubles as the speed and direction of the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pwm_duty        = duty_reg;
    assign drive_direction = state_reg.direction;
    assign current_speed   = state_reg.speed;

endmodule

// ----- dv/tb_motor_speed_ramp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_speed_ramp_top
// Drives ticks into the motor speed ramp through valid/ready, with random
// gaps on both sides and long output hold-offs. Every register setting is
// visited. Each result is checked field by field against a cycle-free model
// of the ramp held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_motor_speed_ramp_top;
    import msr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          PHASES        = 12;
    localparam int          PHASE_TICKS   = 135;

    typedef logic [SPEED_W-1:0] speed_t;

    typedef struct packed {
        speed_t duty;
        logic   direction;
        speed_t speed;
    } ramp_out_t;

    // ------------------------------------------------------------------------
    // Ramp state model plus the queue of outputs still owed by the block
    // ------------------------------------------------------------------------
    class ramp_checker;
        speed_t             held_speed;
        logic               held_dir;
        logic [SHIFT_W-1:0] shift;
        logic               invert;
        ramp_out_t          expected_ticks[$];
        int unsigned        ticks_taken;
        int unsigned        results_checked;
        int unsigned        mismatches;

        function new();
            held_speed      = '0;
            held_dir        = 1'b0;
            shift           = '0;
            invert          = 1'b0;
            ticks_taken     = 0;
            results_checked = 0;
            mismatches      = 0;
        endfunction

        function void write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
            if (idx == CFG_STEP_SHIFT)
                shift = data[SHIFT_W-1:0];
            else
                invert = data[0];
        endfunction

        // Advance the held speed and direction by one tick; queue the outputs.
        function void take_tick(speed_t target, logic tdir, logic fault);
            speed_t    cmd;
            speed_t    spd;
            speed_t    diff;
            speed_t    shifted;
            ramp_out_t r;
            cmd = (target > SPEED_LIMIT) ? SPEED_LIMIT : target;
            if (fault)
                cmd = '0;
            spd = held_speed;
            // direction is only taken over from standstill
            if (spd == '0 && cmd != '0)
                held_dir = tdir;
            if (held_dir != tdir) begin
                if (spd != '0) begin
                    spd = speed_t'(spd - spd / 5);
                    spd = (spd > BRAKE_MIN) ? speed_t'(spd - spd / 5) : '0;
                end
            end
            else if (cmd > spd) begin
                diff = cmd - spd;
                spd  = (diff > SNAP_BAND) ? speed_t'(spd + diff / 5) : cmd;
            end
            else if (cmd < spd) begin
                diff = spd - cmd;
                spd  = (diff > SNAP_BAND) ? speed_t'(spd - diff / 5) : cmd;
            end
            held_speed  = spd;
            shifted     = spd >> shift;
            r.duty      = (invert && held_dir) ? speed_t'((DUTY_TOP >> shift) - shifted)
                                               : shifted;
            r.direction = held_dir;
            r.speed     = spd;
            expected_ticks.push_back(r);
            ticks_taken++;
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
                         results_checked, what, want, got);
        endfunction

        function void check_result(ramp_out_t got);
            ramp_out_t want;
            if (expected_ticks.size() == 0) begin
                flag("result with no tick pending, current_speed", -1, int'(got.speed));
                return;
            end
            want = expected_ticks.pop_front();
            if (got.duty !== want.duty)
                flag("pwm_duty", int'(want.duty), int'(got.duty));
            if (got.direction !== want.direction)
                flag("drive_direction", int'(want.direction), int'(got.direction));
            if (got.speed !== want.speed)
                flag("current_speed", int'(want.speed), int'(got.speed));
            results_checked++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    speed_t             target_speed;
    logic               target_direction;
    logic               motor_fault;
    logic               out_valid;
    logic               out_ready;
    speed_t             pwm_duty;
    logic               drive_direction;
    speed_t             current_speed;

    ramp_checker chk = new();

    int unsigned cycle_count   = 0;
    int unsigned tx_gap_odds   = 0;
    int unsigned rx_stall_odds = 0;
    int unsigned rx_hold_cycles = 0;
    int unsigned long_holds    = 0;
    int unsigned mode_writes   = 0;

    motor_speed_ramp_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .target_speed     (target_speed),
        .target_direction (target_direction),
        .motor_fault      (motor_fault),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pwm_duty         (pwm_duty),
        .drive_direction  (drive_direction),
        .current_speed    (current_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample both handshakes with the values that stood before the edge.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            chk.take_tick(target_speed, target_direction, motor_fault);
        if (out_valid && out_ready)
            chk.check_result({pwm_duty, drive_direction, current_speed});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d ticks still pending",
                     cycle_count, chk.expected_ticks.size());
            $display("tb_motor_speed_ramp_top NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (rx_hold_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                long_holds++;
            end
            else if (rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(speed_t t, logic d, logic f);
        in_valid         <= 1'b1;
        target_speed     <= t;
        target_direction <= d;
        motor_fault      <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Hold off input until every owed result has come out, then let it settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chk.expected_ticks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        chk.write_register(idx, data);
        @(posedge clk);
    endtask

    task automatic set_mode(int unsigned shift, bit inv);
        write_register(CFG_STEP_SHIFT, CFG_W'(shift));
        // upper data bit is don't-care for the invert register
        write_register(CFG_INVERT_REV, {1'($urandom_range(0, 1)), inv});
        mode_writes++;
    endtask

    function automatic speed_t pick_speed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return speed_t'(1023);
            2:       return speed_t'($urandom_range(1, 30));
            3:       return speed_t'($urandom_range(990, 1023));
            default: return speed_t'($urandom_range(0, 1023));
        endcase
    endfunction

    // Mostly held commands so the ramp settles, reverses and brakes;
    // some ticks are pure noise.
    task automatic random_phase(int n);
        speed_t cmd;
        logic   dir;
        int     run;
        run = 0;
        cmd = '0;
        dir = 1'b0;
        repeat (n) begin
            if (run == 0) begin
                run = $urandom_range(1, 24);
                cmd = pick_speed();
                dir = 1'($urandom_range(0, 1));
            end
            run--;
            if ($urandom_range(0, 4) == 0)
                send_tick(speed_t'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else
                send_tick(cmd, dir, $urandom_range(0, 19) == 0);
            maybe_pause();
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_STEP_SHIFT;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        target_speed     <= '0;
        target_direction <= 1'b0;
        motor_fault      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ramp up at full command, fault stop, reversal braking,
        // fault while braking, small commands, restart in reverse.
        rx_stall_odds = 4;
        repeat (6) send_tick(speed_t'(1023), 1'b0, 1'b0);
        send_tick(speed_t'(1023), 1'b0, 1'b1);
        repeat (4) send_tick('0, 1'b1, 1'b0);
        send_tick('0, 1'b1, 1'b1);
        send_tick(speed_t'(20), 1'b0, 1'b0);
        send_tick(speed_t'(5), 1'b0, 1'b0);
        send_tick('0, 1'b0, 1'b0);
        repeat (3) send_tick(speed_t'(1023), 1'b1, 1'b0);
        wait_drained();

        // Shift of three with inversion while in reverse, then a fault brake.
        set_mode(3, 1'b1);
        repeat (2) send_tick(speed_t'(1023), 1'b1, 1'b0);
        send_tick(speed_t'(1023), 1'b0, 1'b1);
        send_tick('0, 1'b1, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8)
                set_mode(p % 4, 1'((p / 4) % 2));
            else
                set_mode($urandom_range(0, 3), 1'($urandom_range(0, 1)));
            if (p == PHASES - 1) begin
                tx_gap_odds   = 0;
                rx_stall_odds = 0;
            end
            else begin
                tx_gap_odds   = (p % 3 == 0) ? 0 : 2 + p % 5;
                rx_stall_odds = (p % 4 == 1) ? 0 : 3 + p % 6;
            end
            // fill the pipe against a blocked output
            if (p == 2 || p == 9)
                rx_hold_cycles = 300;
            if (p == 5) begin
                random_phase(PHASE_TICKS / 2);
                wait_drained();
                random_phase(PHASE_TICKS - PHASE_TICKS / 2);
            end
            else begin
                random_phase(PHASE_TICKS);
            end
            wait_drained();
        end

        $display("Run covered %0d ticks and %0d checked results over %0d register settings,",
                 chk.ticks_taken, chk.results_checked, mode_writes + 1);
        $display("all step shifts with and without reverse inversion, %0d long output holds.",
                 long_holds);
        if (chk.mismatches == 0 && chk.expected_ticks.size() == 0) begin
            $display("tb_motor_speed_ramp_top OK");
        end
        else begin
            $display("%0d mismatches, %0d ticks left without a result",
                     chk.mismatches, chk.expected_ticks.size());
            $display("tb_motor_speed_ramp_top NOT OK");
        end
        $finish;
    end

endmodule
